/* rtl/base64_stream_decoder_assert.svh */
// Assertion macros for the base64 stream decoder.
// Expects clk and arst_n in the scope that uses them.
`ifndef BASE64_STREAM_DECODER_ASSERT_SVH
`define BASE64_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define B64D_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("b64d: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define B64D_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("b64d: next-cycle check failed");

`endif

/* rtl/b64d_pkg.sv */
// Shared types, status codes and alphabet lookup for the base64 decoder.
// No dependencies.
package b64d_pkg;

	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_EMPTY    = 3'd1,
		STAT_BAD_LEN  = 3'd2,
		STAT_BAD_CHAR = 3'd3,
		STAT_BAD_PAD  = 3'd4,
		STAT_CAPACITY = 3'd5
	} status_t;

	localparam logic [7:0] PAD_CHAR = 8'h3D;   // '='

	// Bit 6 set marks a character outside the alphabet.
	typedef logic [6:0] sextet_t;

	function automatic sextet_t sextet_of(input logic [7:0] c);
		sextet_t r;
		r = 7'h40;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = 7'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			r = 7'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r = 7'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2B) begin
			r = 7'd62;
		end else if (c == 8'h2F) begin
			r = 7'd63;
		end
		return r;
	endfunction

endpackage

/* rtl/base64_stream_decoder.sv */
// Base64 stream decoder, standard alphabet with strict '=' padding.
// Depends on b64d_pkg and base64_stream_decoder_assert.svh.
//
// Input channel s_axis: one beat per encoded character (tuser = 0, tdata = the
// ASCII byte) and one closing beat (tuser = 1) that ends the string.
// Output channel m_axis: each completed quartet gives up to three byte beats
// (tuser = 0); the closing beat gives one status beat (tuser = 1). tlast marks
// the final beat produced by one input beat. A status other than ok means the
// receiver drops the bytes of that string.
// cfg channel: writes the byte capacity; write it only while the block is idle.
// Path: a beat is registered at the input, decoded from the input register, and
// its results are registered in the result register, which drives m_axis.
// Throughput: one input beat per cycle while the output drains; a quartet's
// bytes leave one per cycle from the result register, so an input beat that
// gives output waits in the input register until the last bundle beat is taken.
// Reset clears the decoder state and sets the capacity to 128. When m_axis
// stalls, the result register holds, the input register fills and then
// s_axis_tready drops; nothing is lost.
module base64_stream_decoder #(
	parameter int MAX_CAPACITY = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] ch
	input  logic        s_axis_tuser,   // [0] func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [7:0] data_byte, [10:8] status, [23:11] byte_count
	output logic        m_axis_tuser,   // [0] is_status
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [12:0] cfg_data        // out_capacity
);
	import b64d_pkg::*;

	// configuration
	logic [12:0] out_capacity_q;
	logic [13:0] cap;

	// input register
	logic       valid_s1;
	logic       func_s1;
	logic [7:0] ch_s1;

	// decoder state
	logic [1:0]  quartet_pos_q;
	logic [17:0] held_q;
	logic        third_is_pad_q;
	logic        padded_done_q;
	logic        seen_any_q;
	status_t     first_error_q;
	logic [12:0] out_count_q;

	logic [1:0]  quartet_pos_d;
	logic [17:0] held_d;
	logic        third_is_pad_d;
	logic        padded_done_d;
	logic        seen_any_d;
	status_t     first_error_d;
	logic [12:0] out_count_d;

	// decode results for the item in the input register
	logic [1:0]  res_n;
	logic        res_is_status;
	status_t     res_status;
	logic [7:0]  res_data [3];
	logic [12:0] res_count [3];

	// result register
	logic        ob_valid_q;
	logic [1:0]  ob_n_q;
	logic [1:0]  ob_idx_q;
	logic        ob_is_status_q;
	status_t     ob_status_q;
	logic [7:0]  ob_data_q [3];
	logic [12:0] ob_count_q [3];

	logic ob_take;
	logic ob_last_beat;
	logic ob_free;
	logic adv_s1;

	// decode helpers
	sextet_t     sx;
	logic        bad;
	logic        is_pad;
	logic [23:0] triple;
	logic [1:0]  want;
	logic        room0, room1, room2;
	status_t     end_status;

	// -------- configuration --------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_capacity_q <= 13'd128;
		end else if (cfg_valid && cfg_ready) begin
			out_capacity_q <= cfg_data;
		end
	end

	assign cap = (int'(out_capacity_q) > MAX_CAPACITY) ? 14'(MAX_CAPACITY)
		: {1'b0, out_capacity_q};

	// -------- handshakes --------
	assign ob_take      = ob_valid_q && m_axis_tready;
	assign ob_last_beat = (ob_idx_q == ob_n_q - 2'd1);
	assign ob_free      = !ob_valid_q || (ob_take && ob_last_beat);
	assign adv_s1       = valid_s1 && ((res_n == 2'd0) || ob_free);
	assign s_axis_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			func_s1 <= s_axis_tuser;
			ch_s1   <= s_axis_tdata;
		end
	end

	// -------- decode --------
	assign sx     = sextet_of(ch_s1);
	assign bad    = sx[6];
	assign is_pad = (ch_s1 == PAD_CHAR);
	assign triple = {held_q, (is_pad ? 6'd0 : sx[5:0])};
	assign want   = 2'd1 + {1'b0, !third_is_pad_q} + {1'b0, !is_pad};
	assign room0  = ({1'b0, out_count_q}) < cap;
	assign room1  = ({1'b0, out_count_q} + 14'd1) < cap;
	assign room2  = ({1'b0, out_count_q} + 14'd2) < cap;

	always_comb begin
		if (!seen_any_q) begin
			end_status = STAT_EMPTY;
		end else if (quartet_pos_q != 2'd0) begin
			end_status = STAT_BAD_LEN;
		end else begin
			end_status = first_error_q;
		end
	end

	always_comb begin
		quartet_pos_d  = quartet_pos_q;
		held_d         = held_q;
		third_is_pad_d = third_is_pad_q;
		padded_done_d  = padded_done_q;
		seen_any_d     = seen_any_q;
		first_error_d  = first_error_q;
		out_count_d    = out_count_q;
		res_n          = 2'd0;
		res_is_status  = 1'b0;
		res_status     = STAT_OK;
		res_data[0]    = triple[23:16];
		res_data[1]    = triple[15:8];
		res_data[2]    = triple[7:0];
		res_count[0]   = out_count_q + 13'd1;
		res_count[1]   = out_count_q + 13'd2;
		res_count[2]   = out_count_q + 13'd3;

		if (func_s1) begin
			res_n         = 2'd1;
			res_is_status = 1'b1;
			res_status    = end_status;
			res_data[0]   = 8'd0;
			res_count[0]  = (end_status == STAT_OK) ? out_count_q : 13'd0;
			// start a new string
			quartet_pos_d  = 2'd0;
			held_d         = 18'd0;
			third_is_pad_d = 1'b0;
			padded_done_d  = 1'b0;
			seen_any_d     = 1'b0;
			first_error_d  = STAT_OK;
			out_count_d    = 13'd0;
		end else begin
			quartet_pos_d = quartet_pos_q + 2'd1;
			seen_any_d    = 1'b1;
			if (padded_done_q) begin
				// anything after a padded quartet is bad padding
				if (first_error_q == STAT_OK || first_error_q == STAT_CAPACITY) begin
					first_error_d = STAT_BAD_PAD;
				end
			end else if (first_error_q == STAT_OK) begin
				case (quartet_pos_q)
					2'd0, 2'd1: begin
						if (bad) begin
							first_error_d = STAT_BAD_CHAR;
						end else if (quartet_pos_q == 2'd0) begin
							held_d = {12'd0, sx[5:0]};
						end else begin
							held_d = {held_q[11:0], sx[5:0]};
						end
					end
					2'd2: begin
						if (is_pad) begin
							third_is_pad_d = 1'b1;
							held_d         = {held_q[11:0], 6'd0};
						end else if (bad) begin
							first_error_d = STAT_BAD_CHAR;
						end else begin
							third_is_pad_d = 1'b0;
							held_d         = {held_q[11:0], sx[5:0]};
						end
					end
					default: begin
						if (!is_pad && bad) begin
							first_error_d = STAT_BAD_CHAR;
						end else if (third_is_pad_q && !is_pad) begin
							first_error_d = STAT_BAD_PAD;
						end else begin
							// stop at the capacity limit, keep what was sent
							if (!room0) begin
								res_n         = 2'd0;
								first_error_d = STAT_CAPACITY;
							end else if (want >= 2'd2 && !room1) begin
								res_n         = 2'd1;
								first_error_d = STAT_CAPACITY;
							end else if (want == 2'd3 && !room2) begin
								res_n         = 2'd2;
								first_error_d = STAT_CAPACITY;
							end else begin
								res_n = want;
							end
							out_count_d    = out_count_q + {11'd0, res_n};
							padded_done_d  = is_pad;
							third_is_pad_d = 1'b0;
							held_d         = 18'd0;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quartet_pos_q  <= 2'd0;
			held_q         <= 18'd0;
			third_is_pad_q <= 1'b0;
			padded_done_q  <= 1'b0;
			seen_any_q     <= 1'b0;
			first_error_q  <= STAT_OK;
			out_count_q    <= 13'd0;
		end else if (adv_s1) begin
			quartet_pos_q  <= quartet_pos_d;
			held_q         <= held_d;
			third_is_pad_q <= third_is_pad_d;
			padded_done_q  <= padded_done_d;
			seen_any_q     <= seen_any_d;
			first_error_q  <= first_error_d;
			out_count_q    <= out_count_d;
		end
	end

	// -------- result register --------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_valid_q <= 1'b0;
			ob_n_q     <= 2'd1;
			ob_idx_q   <= 2'd0;
		end else if (adv_s1 && res_n != 2'd0) begin
			ob_valid_q <= 1'b1;
			ob_n_q     <= res_n;
			ob_idx_q   <= 2'd0;
		end else if (ob_take) begin
			// advance through the bundle, drop it after its last beat
			ob_valid_q <= !ob_last_beat;
			ob_idx_q   <= ob_idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res_n != 2'd0) begin
			ob_is_status_q <= res_is_status;
			ob_status_q    <= res_status;
			ob_data_q      <= res_data;
			ob_count_q     <= res_count;
		end
	end

	assign m_axis_tvalid = ob_valid_q;
	assign m_axis_tuser  = ob_is_status_q;
	assign m_axis_tlast  = ob_last_beat;
	assign m_axis_tdata  = {ob_count_q[ob_idx_q], ob_status_q, ob_data_q[ob_idx_q]};

	// -------- assertions --------
`include "base64_stream_decoder_assert.svh"

	`B64D_ASSERT_NOW(a_idx_in_bundle, ob_valid_q, ob_idx_q < ob_n_q)
	`B64D_ASSERT_NOW(a_status_is_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
	`B64D_ASSERT_NOW(a_count_within_cap, 1'b1, {1'b0, out_count_q} <= cap)
	`B64D_ASSERT_NEXT(a_end_clears, adv_s1 && func_s1,
		quartet_pos_q == 2'd0 && out_count_q == 13'd0 && !seen_any_q)

endmodule
